// ===== hdl/tvas_pkg.sv =====
`default_nettype none

package tvas_pkg;

    localparam int unsigned TIMER_BITS_DEFAULT = 24;

    localparam int unsigned DURATION_W = 24;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 8;

    localparam logic [DURATION_W-1:0] OVERLAP_MS_RESET    = 24'd750;
    localparam logic [DURATION_W-1:0] TOWER_OPEN_MS_RESET = 24'd59250;
    localparam logic [LEVEL_W-1:0]    SUPPLY_ON_RESET     = 16'd900;
    localparam logic [LEVEL_W-1:0]    SUPPLY_OFF_RESET    = 16'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLAP_MS    = 2'd0,
        REG_TOWER_OPEN_MS = 2'd1,
        REG_SUPPLY_ON     = 2'd2,
        REG_SUPPLY_OFF    = 2'd3
    } reg_index_t;

    typedef enum logic {
        CMD_TICK       = 1'b0,
        CMD_SET_ENABLE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        PH_INACTIVE = 3'd0,
        PH_LEFT     = 3'd1,
        PH_BOTH_L   = 3'd2,
        PH_RIGHT    = 3'd3,
        PH_BOTH_R   = 3'd4,
        PH_LOW      = 3'd5
    } phase_t;

    typedef struct packed {
        logic   enabled;
        phase_t phase;
    } ctl_t;

    typedef struct packed {
        logic [DURATION_W-1:0] overlap_ms;
        logic [DURATION_W-1:0] tower_open_ms;
        logic [LEVEL_W-1:0]    supply_on_level;
        logic [LEVEL_W-1:0]    supply_off_level;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/twin_valve_alternation_sequencer_unit.sv =====
// Twin valve alternation sequencer.
// The input stream carries one item per transfer: s_tuser selects a one
// millisecond tick (with a supply pressure sample in s_tdata) or a set-enable
// command (with the requested level in s_tdata). Every input transfer yields
// exactly one output transfer that reports the phase, both valve drives and
// the enable flag as they stand after that item.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must write them only while the stream is idle; the block does not enforce
// this. They take effect on the next item. An item passes through the input
// register, then through the update logic into the result register.
// Throughput is one item per cycle while the receiver holds m_tready high.
// When the receiver holds m_tready low, the result register and then the
// input register fill and s_tready drops; no item is lost or repeated.
// After reset the block is disabled in the inactive phase with the timer at
// zero, both valves closed, and the registers at their default values.
`default_nettype none

module twin_valve_alternation_sequencer_unit #(
    parameter int unsigned TIMER_BITS = tvas_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tvas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] supply_psi_x10, [16] enable_value, [23:17] zero
    input  logic [tvas_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] phase, [3] left_valve_on, [4] right_valve_on, [5] is_enabled,
    // [7:6] zero
    output logic [tvas_pkg::M_DATA_W-1:0]     m_tdata
);

    tvas_pkg::cfg_t                     cfg_reg;
    tvas_pkg::ctl_t                     ctl_reg;
    tvas_pkg::ctl_t                     ctl_next;
    logic [TIMER_BITS-1:0]              elapsed_reg;
    logic [TIMER_BITS-1:0]              elapsed_next;

    logic                               in_valid_reg;
    tvas_pkg::cmd_t                     in_cmd_reg;
    logic [tvas_pkg::LEVEL_W-1:0]       in_psi_reg;
    logic                               in_enable_reg;

    logic                               out_valid_reg;
    logic [tvas_pkg::M_DATA_W-1:0]      out_data_reg;
    logic [tvas_pkg::M_DATA_W-1:0]      out_data_next;

    logic                               advance;
    logic                               left_on;
    logic                               right_on;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overlap_ms       <= tvas_pkg::OVERLAP_MS_RESET;
            cfg_reg.tower_open_ms    <= tvas_pkg::TOWER_OPEN_MS_RESET;
            cfg_reg.supply_on_level  <= tvas_pkg::SUPPLY_ON_RESET;
            cfg_reg.supply_off_level <= tvas_pkg::SUPPLY_OFF_RESET;
        end else if (cfg_wr_en) begin
            case (tvas_pkg::reg_index_t'(cfg_index))
                tvas_pkg::REG_OVERLAP_MS:
                    cfg_reg.overlap_ms <= cfg_data;
                tvas_pkg::REG_TOWER_OPEN_MS:
                    cfg_reg.tower_open_ms <= cfg_data;
                tvas_pkg::REG_SUPPLY_ON:
                    cfg_reg.supply_on_level <= cfg_data[tvas_pkg::LEVEL_W-1:0];
                tvas_pkg::REG_SUPPLY_OFF:
                    cfg_reg.supply_off_level <= cfg_data[tvas_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg    <= tvas_pkg::cmd_t'(s_tuser);
            in_psi_reg    <= s_tdata[tvas_pkg::LEVEL_W-1:0];
            in_enable_reg <= s_tdata[tvas_pkg::LEVEL_W];
        end
    end

    tvas_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg            (cfg_reg),
        .ctl            (ctl_reg),
        .elapsed        (elapsed_reg),
        .cmd            (in_cmd_reg),
        .supply_psi_x10 (in_psi_reg),
        .enable_value   (in_enable_reg),
        .ctl_next       (ctl_next),
        .elapsed_next   (elapsed_next)
    );

    always_comb begin
        case (ctl_next.phase)
            tvas_pkg::PH_LEFT:   begin left_on = 1'b1; right_on = 1'b0; end
            tvas_pkg::PH_BOTH_L: begin left_on = 1'b1; right_on = 1'b1; end
            tvas_pkg::PH_RIGHT:  begin left_on = 1'b0; right_on = 1'b1; end
            tvas_pkg::PH_BOTH_R: begin left_on = 1'b1; right_on = 1'b1; end
            default:             begin left_on = 1'b0; right_on = 1'b0; end
        endcase
    end

    assign out_data_next = {2'b00, ctl_next.enabled, right_on, left_on, ctl_next.phase};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.enabled <= 1'b0;
            ctl_reg.phase   <= tvas_pkg::PH_INACTIVE;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                ctl_reg     <= ctl_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    a_disabled_is_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl_reg.enabled |-> ctl_reg.phase == tvas_pkg::PH_INACTIVE)
        else $error("phase left inactive while disabled");

    a_timer_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (elapsed_reg >= $past(elapsed_reg)) || (elapsed_reg == '0))
        else $error("phase timer moved backward without a phase change");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input accepted while both stages are full");

endmodule

`default_nettype wire

// ===== hdl/tvas_step.sv =====
`default_nettype none

module tvas_step #(
    parameter int unsigned TIMER_BITS = tvas_pkg::TIMER_BITS_DEFAULT
) (
    input  tvas_pkg::cfg_t                  cfg,
    input  tvas_pkg::ctl_t                  ctl,
    input  logic [TIMER_BITS-1:0]           elapsed,
    input  tvas_pkg::cmd_t                  cmd,
    input  logic [tvas_pkg::LEVEL_W-1:0]    supply_psi_x10,
    input  logic                            enable_value,
    output tvas_pkg::ctl_t                  ctl_next,
    output logic [TIMER_BITS-1:0]           elapsed_next
);

    localparam int unsigned CMP_W =
        (TIMER_BITS > tvas_pkg::DURATION_W) ? TIMER_BITS : tvas_pkg::DURATION_W;

    logic [TIMER_BITS-1:0]             elapsed_inc;
    logic [tvas_pkg::DURATION_W-1:0]   phase_len;
    logic                              cycling;
    logic                              expired;
    tvas_pkg::phase_t                  advance_phase;

    assign elapsed_inc = (elapsed == {TIMER_BITS{1'b1}}) ? elapsed
                                                         : elapsed + 1'b1;

    assign cycling = (ctl.phase == tvas_pkg::PH_LEFT)   ||
                     (ctl.phase == tvas_pkg::PH_BOTH_L) ||
                     (ctl.phase == tvas_pkg::PH_RIGHT)  ||
                     (ctl.phase == tvas_pkg::PH_BOTH_R);

    assign phase_len = ((ctl.phase == tvas_pkg::PH_LEFT) ||
                        (ctl.phase == tvas_pkg::PH_RIGHT)) ? cfg.tower_open_ms
                                                           : cfg.overlap_ms;

    assign expired = CMP_W'(elapsed_inc) >= CMP_W'(phase_len);

    always_comb begin
        case (ctl.phase)
            tvas_pkg::PH_LEFT:   advance_phase = tvas_pkg::PH_BOTH_L;
            tvas_pkg::PH_BOTH_L: advance_phase = tvas_pkg::PH_RIGHT;
            tvas_pkg::PH_RIGHT:  advance_phase = tvas_pkg::PH_BOTH_R;
            default:             advance_phase = tvas_pkg::PH_LEFT;
        endcase
    end

    always_comb begin
        ctl_next     = ctl;
        elapsed_next = elapsed;
        case (cmd)
            tvas_pkg::CMD_TICK: begin
                elapsed_next = elapsed_inc;
                if (ctl.enabled) begin
                    if (cycling) begin
                        if (supply_psi_x10 <= cfg.supply_off_level) begin
                            ctl_next.phase = tvas_pkg::PH_LOW;
                            elapsed_next   = '0;
                        end else if (expired) begin
                            ctl_next.phase = advance_phase;
                            elapsed_next   = '0;
                        end
                    end else if (supply_psi_x10 >= cfg.supply_on_level) begin
                        ctl_next.phase = tvas_pkg::PH_LEFT;
                        elapsed_next   = '0;
                    end
                end
            end
            tvas_pkg::CMD_SET_ENABLE: begin
                if (enable_value != ctl.enabled) begin
                    ctl_next.enabled = enable_value;
                    ctl_next.phase   = enable_value ? tvas_pkg::PH_LEFT
                                                    : tvas_pkg::PH_INACTIVE;
                    elapsed_next     = '0;
                end
            end
            default: begin
                ctl_next     = ctl;
                elapsed_next = elapsed;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/tvas_checker.sv =====
`timescale 1ns / 1ps

module tvas_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tvas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvas_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tvas_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tvas_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              error_count,
    output int                              outstanding
);

    localparam int unsigned TIMER_W = tvas_pkg::TIMER_BITS_DEFAULT;

    typedef struct packed {
        logic             enabled;
        logic             right_on;
        logic             left_on;
        tvas_pkg::phase_t phase;
    } valve_report_t;

    tvas_pkg::cfg_t     valve_cfg;
    logic               enabled_now;
    tvas_pkg::phase_t   phase_now;
    logic [TIMER_W-1:0] ms_in_phase;
    valve_report_t      report_q[$];
    int                 mismatch_total;

    task automatic enter_phase(input tvas_pkg::phase_t next_phase);
        phase_now   = next_phase;
        ms_in_phase = '0;
    endtask

    task automatic advance_valves(input tvas_pkg::cmd_t cmd,
                                  input logic [tvas_pkg::LEVEL_W-1:0] psi,
                                  input logic want);
        logic [tvas_pkg::DURATION_W-1:0] span;
        if (cmd == tvas_pkg::CMD_TICK) begin
            if (ms_in_phase != '1) begin
                ms_in_phase = ms_in_phase + 1'b1;
            end
            if (enabled_now) begin
                if (phase_now inside {tvas_pkg::PH_LEFT, tvas_pkg::PH_BOTH_L,
                                      tvas_pkg::PH_RIGHT, tvas_pkg::PH_BOTH_R}) begin
                    span = (phase_now == tvas_pkg::PH_LEFT ||
                            phase_now == tvas_pkg::PH_RIGHT) ?
                           valve_cfg.tower_open_ms : valve_cfg.overlap_ms;
                    if (psi <= valve_cfg.supply_off_level) begin
                        enter_phase(tvas_pkg::PH_LOW);
                    end else if (ms_in_phase >= span) begin
                        case (phase_now)
                            tvas_pkg::PH_LEFT:   enter_phase(tvas_pkg::PH_BOTH_L);
                            tvas_pkg::PH_BOTH_L: enter_phase(tvas_pkg::PH_RIGHT);
                            tvas_pkg::PH_RIGHT:  enter_phase(tvas_pkg::PH_BOTH_R);
                            default:             enter_phase(tvas_pkg::PH_LEFT);
                        endcase
                    end
                end else if (psi >= valve_cfg.supply_on_level) begin
                    enter_phase(tvas_pkg::PH_LEFT);
                end
            end
        end else if (want != enabled_now) begin
            enabled_now = want;
            enter_phase(want ? tvas_pkg::PH_LEFT : tvas_pkg::PH_INACTIVE);
        end
    endtask

    always @(posedge aclk) begin : monitor
        valve_report_t got;
        valve_report_t want_r;
        if (!aresetn) begin
            valve_cfg.overlap_ms       = tvas_pkg::OVERLAP_MS_RESET;
            valve_cfg.tower_open_ms    = tvas_pkg::TOWER_OPEN_MS_RESET;
            valve_cfg.supply_on_level  = tvas_pkg::SUPPLY_ON_RESET;
            valve_cfg.supply_off_level = tvas_pkg::SUPPLY_OFF_RESET;
            enabled_now    = 1'b0;
            phase_now      = tvas_pkg::PH_INACTIVE;
            ms_in_phase    = '0;
            mismatch_total = 0;
            report_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (tvas_pkg::reg_index_t'(cfg_index))
                    tvas_pkg::REG_OVERLAP_MS:
                        valve_cfg.overlap_ms = cfg_data[tvas_pkg::DURATION_W-1:0];
                    tvas_pkg::REG_TOWER_OPEN_MS:
                        valve_cfg.tower_open_ms = cfg_data[tvas_pkg::DURATION_W-1:0];
                    tvas_pkg::REG_SUPPLY_ON:
                        valve_cfg.supply_on_level = cfg_data[tvas_pkg::LEVEL_W-1:0];
                    tvas_pkg::REG_SUPPLY_OFF:
                        valve_cfg.supply_off_level = cfg_data[tvas_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_valves(tvas_pkg::cmd_t'(s_tuser), s_tdata[tvas_pkg::LEVEL_W-1:0],
                               s_tdata[tvas_pkg::LEVEL_W]);
                want_r.phase    = phase_now;
                want_r.left_on  = phase_now inside {tvas_pkg::PH_LEFT, tvas_pkg::PH_BOTH_L,
                                                    tvas_pkg::PH_BOTH_R};
                want_r.right_on = phase_now inside {tvas_pkg::PH_RIGHT, tvas_pkg::PH_BOTH_L,
                                                    tvas_pkg::PH_BOTH_R};
                want_r.enabled  = enabled_now;
                report_q.push_back(want_r);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[5:0];
                if (report_q.size() == 0) begin
                    if (mismatch_total < 10) begin
                        $display("%0t: result transfer 0x%02h arrived with nothing expected",
                                 $realtime, m_tdata);
                    end
                    mismatch_total++;
                end else begin
                    want_r = report_q.pop_front();
                    if (got.phase != want_r.phase || got.left_on != want_r.left_on ||
                        got.right_on != want_r.right_on || got.enabled != want_r.enabled) begin
                        if (mismatch_total < 10) begin
                            $display({"%0t: phase %0d/%0d left %0b/%0b right %0b/%0b ",
                                      "en %0b/%0b (exp/got)"},
                                     $realtime, want_r.phase, got.phase,
                                     want_r.left_on, got.left_on, want_r.right_on,
                                     got.right_on, want_r.enabled, got.enabled);
                        end
                        mismatch_total++;
                    end
                end
            end
        end
        error_count <= mismatch_total;
        outstanding <= report_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_BURSTY
    } rx_mode_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tvas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tvas_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [tvas_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [tvas_pkg::M_DATA_W-1:0]   m_tdata;

    int error_count;
    int outstanding;

    int       idle_cycles = 0;
    rx_mode_t rx_mode     = RX_STREAM;
    int       rx_epoch    = 0;
    int       rx_span     = 0;

    int burst_left = 0;
    int level_on   = 900;
    int level_off  = 700;

    twin_valve_alternation_sequencer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tvas_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (rx_epoch == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 2));
            rx_epoch <= 300;
        end else begin
            rx_epoch <= rx_epoch - 1;
        end
        if (rx_span != 0) begin
            rx_span <= rx_span - 1;
        end else begin
            case (rx_mode)
                RX_STREAM: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (m_tready) begin
                        m_tready <= 1'b0;
                        rx_span  <= $urandom_range(0, 15);
                    end else begin
                        m_tready <= 1'b1;
                        rx_span  <= $urandom_range(0, 3);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input tvas_pkg::cmd_t cmd,
                             input logic [tvas_pkg::LEVEL_W-1:0] psi, input logic want);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, want, psi};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_tick(input logic [tvas_pkg::LEVEL_W-1:0] psi);
        send_item(tvas_pkg::CMD_TICK, psi, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_enable(input logic want);
        send_item(tvas_pkg::CMD_SET_ENABLE, 16'($urandom_range(0, 65535)), want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input tvas_pkg::reg_index_t idx,
                             input logic [tvas_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [tvas_pkg::DURATION_W-1:0] overlap,
                              input logic [tvas_pkg::DURATION_W-1:0] tower,
                              input logic [tvas_pkg::LEVEL_W-1:0] on_level,
                              input logic [tvas_pkg::LEVEL_W-1:0] off_level);
        wait_drained();
        write_reg(tvas_pkg::REG_OVERLAP_MS, overlap);
        write_reg(tvas_pkg::REG_TOWER_OPEN_MS, tower);
        write_reg(tvas_pkg::REG_SUPPLY_ON, {8'd0, on_level});
        write_reg(tvas_pkg::REG_SUPPLY_OFF, {8'd0, off_level});
        cfg_wr_en <= 1'b0;
        level_on  = on_level;
        level_off = off_level;
        @(posedge aclk);
    endtask

    function automatic logic [tvas_pkg::LEVEL_W-1:0] pick_pressure();
        int sel;
        int floor_level;
        int val;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            floor_level = ((level_on > level_off) ? level_on : level_off) + 1;
            if (floor_level > 65535) floor_level = 65535;
            val = $urandom_range(floor_level, 65535);
        end else if (sel < 70) begin
            val = ($urandom_range(0, 1) ? level_on : level_off) +
                  int'($urandom_range(0, 4)) - 2;
            if (val < 0) val = 0;
            if (val > 65535) val = 65535;
        end else if (sel < 85) begin
            val = $urandom_range(0, 65535);
        end else begin
            val = $urandom_range(0, level_off);
        end
        return val[tvas_pkg::LEVEL_W-1:0];
    endfunction

    task automatic run_random(input int tick_count);
        int ticks_sent;
        ticks_sent = 0;
        while (ticks_sent < tick_count) begin
            if ($urandom_range(0, 99) < 5) begin
                send_enable($urandom_range(0, 3) != 0);
            end else begin
                send_tick(pick_pressure());
                ticks_sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_tick(16'hFFFF);
        send_enable(1'b0);
        send_enable(1'b1);
        send_enable(1'b1);
        send_tick(16'd701);
        send_tick(16'd700);
        send_tick(16'd899);
        send_tick(16'd900);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_enable(1'b0);
        send_tick(16'hFFFF);

        set_config(24'd0, 24'd0, 16'd900, 16'd700);
        send_enable(1'b1);
        repeat (6) send_tick(16'd1000);
        send_tick(16'd700);
        send_tick(16'hFFFF);
        send_enable(1'b0);

        set_config(24'd3, 24'd10, 16'd900, 16'd700);
        run_random(200);
        set_config(24'd0, 24'd0, 16'd0, 16'hFFFF);
        run_random(200);
        set_config(24'hFFFFFF, 24'd5, 16'hFFFF, 16'd0);
        run_random(200);
        set_config(24'd1, 24'hFFFFFF, 16'd1200, 16'd1300);
        run_random(200);
        set_config(24'd7, 24'd2, 16'd40000, 16'd20000);
        run_random(200);
        repeat (2) begin
            set_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 40)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            run_random(200);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
